// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the render queue RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define DRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DRQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DRQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/drq_pkg.sv -----
// Package for the depth-sorted render queue: sizes, codes, entry and cell control types.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none
package drq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VIEW_MARGIN = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int SIZE_W     = 13;
  localparam int LIMIT_W    = 15;
  localparam int HALF_W     = SIZE_W - 1;
  localparam int CTR_W      = 25;   // camera centre, signed Q16.8
  localparam int SUM_W      = 26;
  localparam int VIEW_W     = 17;
  localparam int BND_W      = 19;

  localparam logic [SIZE_W-1:0]  RST_VIEW_WIDTH   = SIZE_W'(1280);
  localparam logic [SIZE_W-1:0]  RST_VIEW_HEIGHT  = SIZE_W'(720);
  localparam logic [LIMIT_W-1:0] RST_LIMIT_RIGHT  = LIMIT_W'(1280);
  localparam logic [LIMIT_W-1:0] RST_LIMIT_BOTTOM = LIMIT_W'(720);

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BOTTOM = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_PUSH   = 3'd1,
    OP_RENDER = 3'd2,
    OP_SET    = 3'd3,
    OP_RIGHT  = 3'd4,
    OP_LEFT   = 3'd5,
    OP_UP     = 3'd6,
    OP_DOWN   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_OBJ   = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_OVF   = 2'd2,
    KIND_VIEW  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAM,
    ST_CLAMP,
    ST_VIEW,
    ST_PREP,
    ST_BND,
    ST_RENDER,
    ST_FRAME
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_mode_t;

  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } entry_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     new_ent;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/drq_cell.sv -----
// One slot of the sorted queue chain: holds an entry, shifts on insert, rotates on render.
// Depends on drq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drq_cell
  import drq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,       // slot lies below the fill count
  input  logic      tail,      // last occupied slot
  input  logic      gt_left,   // left neighbor sorts after the new entry
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  input  entry_t    head_ent,
  output entry_t    ent,
  output logic      gt
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Empty slots count as "after" so the new entry lands at the fill point.
  assign gt  = !occ || (ent_r.y > ctl.new_ent.y);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.mode)
      CELL_INSERT: begin
        if (gt) begin
          ent_nxt = gt_left ? left_ent : ctl.new_ent;
        end
      end
      CELL_ROTATE: begin
        if (occ) begin
          ent_nxt = tail ? head_ent : right_ent;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/drq_view.sv -----
// View edge computation: centre truncated toward zero, minus half the window size.
// Depends on drq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drq_view
  import drq_pkg::*;
(
  input  logic signed [CTR_W-1:0]  centre_x,
  input  logic signed [CTR_W-1:0]  centre_y,
  input  logic        [HALF_W-1:0] half_w,
  input  logic        [HALF_W-1:0] half_h,
  output logic signed [VIEW_W-1:0] view_left,
  output logic signed [VIEW_W-1:0] view_top
);

  function automatic logic signed [VIEW_W-1:0] edge_of(input logic signed [CTR_W-1:0] c,
                                                       input logic [HALF_W-1:0] half);
    logic signed [VIEW_W-1:0] q;
    logic signed [VIEW_W:0]   d;
    begin
      q = c[CTR_W-1:8];
      // floor shift, then step back toward zero for negative fractions
      if (c[CTR_W-1] && (c[7:0] != 8'd0)) begin
        q = q + VIEW_W'(1);
      end
      d = $signed({q[VIEW_W-1], q}) - $signed({{(VIEW_W + 1 - HALF_W){1'b0}}, half});
      return d[VIEW_W-1:0];
    end
  endfunction

  assign view_left = edge_of(centre_x, half_w);
  assign view_top  = edge_of(centre_y, half_h);

endmodule
`default_nettype wire

// ----- rtl/depth_sorted_render_queue_unit.sv -----
// Depth-sorted render queue: clear and push leave busy low; an overflow result shows the
// cycle after the push. Set centre keeps busy in ST_CAM and ST_VIEW, moves in ST_CAM,
// ST_CLAMP and ST_VIEW, then the view result shows. Render keeps busy in ST_PREP and ST_BND,
// which set up the window, and ST_RENDER, where the chain rotates one entry past the head
// per cycle, then the end-of-frame result. Results cannot be stalled. Synchronous reset
// empties the queue (count only, no clearing pass), zeroes the centre, loads window defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module depth_sorted_render_queue_unit
  import drq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration writes
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic        [2:0]            in_op,
  input  logic        [15:0]           in_object_id,
  input  logic signed [15:0]           in_coord_x,
  input  logic signed [15:0]           in_coord_y,
  input  logic        [15:0]           in_offset,
  // result channel
  output logic                         out_valid,
  output logic        [1:0]            out_kind,
  output logic        [15:0]           out_object_id_res,
  output logic signed [VIEW_W-1:0]     out_view_left,
  output logic signed [VIEW_W-1:0]     out_view_top,
  output logic                         out_last
);

  // ---------------------------------------------------------------------------
  // Control and configuration state
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rot_cnt_r, rot_cnt_nxt;
  logic [SIZE_W-1:0]   width_r, width_nxt;
  logic [SIZE_W-1:0]   height_r, height_nxt;
  logic [LIMIT_W-1:0]  lim_right_r, lim_right_nxt;
  logic [LIMIT_W-1:0]  lim_bottom_r, lim_bottom_nxt;
  logic signed [CTR_W-1:0] centre_x_r, centre_x_nxt;
  logic signed [CTR_W-1:0] centre_y_r, centre_y_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers (no reset)
  op_t                 op_r, op_nxt;
  logic signed [15:0]  x_in_r, x_in_nxt;
  logic signed [15:0]  y_in_r, y_in_nxt;
  logic [15:0]         off_r, off_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SUM_W-1:0]  bound_r, bound_nxt;
  logic signed [VIEW_W-1:0] left_r, left_nxt;
  logic signed [VIEW_W-1:0] top_r, top_nxt;
  logic signed [BND_W-1:0]  lo_x_r, lo_x_nxt, hi_x_r, hi_x_nxt;
  logic signed [BND_W-1:0]  lo_y_r, lo_y_nxt, hi_y_r, hi_y_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [15:0]         out_id_r, out_id_nxt;
  logic signed [VIEW_W-1:0] out_left_r, out_left_nxt;
  logic signed [VIEW_W-1:0] out_top_r, out_top_nxt;
  logic                out_last_r, out_last_nxt;

  logic accept;
  logic full;
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));

  // ---------------------------------------------------------------------------
  // Slot chain: slot 0 is the head (smallest y). A push shifts the tail part right
  // by one; render rotates the occupied part left so each entry passes the head once
  // and the order is restored once every entry has passed.
  // ---------------------------------------------------------------------------
  cell_ctl_t            cell_ctl;
  entry_t               cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt_vec;
  logic [QUEUE_DEPTH-1:0] occ_vec;
  logic [QUEUE_DEPTH-1:0] tail_vec;
  entry_t               head_ent;

  assign head_ent = cell_ent[0];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_ent;
      entry_t right_ent;
      logic   gt_left;

      assign occ_vec[gi]  = (CNT_W'(gi) < count_r);
      assign tail_vec[gi] = (CNT_W'(gi + 1) == count_r);

      if (gi == 0) begin : g_head
        assign left_ent = cell_ctl.new_ent;
        assign gt_left  = 1'b0;
      end else begin : g_body
        assign left_ent = cell_ent[gi-1];
        assign gt_left  = gt_vec[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_end
        assign right_ent = head_ent;
      end else begin : g_mid
        assign right_ent = cell_ent[gi+1];
      end

      drq_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .occ       (occ_vec[gi]),
        .tail      (tail_vec[gi]),
        .gt_left   (gt_left),
        .left_ent  (left_ent),
        .right_ent (right_ent),
        .head_ent  (head_ent),
        .ent       (cell_ent[gi]),
        .gt        (gt_vec[gi])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // View edges from the current centre (used for render setup and view results)
  // ---------------------------------------------------------------------------
  logic signed [VIEW_W-1:0] cur_left, cur_top;

  drq_view u_view (
    .centre_x  (centre_x_r),
    .centre_y  (centre_y_r),
    .half_w    (width_r[SIZE_W-1:1]),
    .half_h    (height_r[SIZE_W-1:1]),
    .view_left (cur_left),
    .view_top  (cur_top)
  );

  // ---------------------------------------------------------------------------
  // Camera move helpers
  // ---------------------------------------------------------------------------
  logic                     axis_y, dir_up;
  logic signed [CTR_W-1:0]  c_sel;
  logic [HALF_W-1:0]        half_sel;
  logic [LIMIT_W-1:0]       lim_sel;
  logic signed [LIMIT_W+1:0] lim_diff;
  logic                     clamp_hit;
  logic signed [CTR_W-1:0]  c_new;

  assign axis_y   = (op_r == OP_UP) || (op_r == OP_DOWN);
  assign dir_up   = (op_r == OP_RIGHT) || (op_r == OP_DOWN);
  assign c_sel    = axis_y ? centre_y_r : centre_x_r;
  assign half_sel = axis_y ? height_r[SIZE_W-1:1] : width_r[SIZE_W-1:1];
  assign lim_sel  = axis_y ? lim_bottom_r : lim_right_r;
  assign lim_diff = $signed({2'b00, lim_sel}) - $signed({5'b00000, half_sel});
  assign clamp_hit = dir_up ? (sum_r >= bound_r) : (sum_r <= bound_r);
  assign c_new     = clamp_hit ? bound_r[CTR_W-1:0] : sum_r[CTR_W-1:0];

  // Visibility of the entry at the head during render
  logic signed [BND_W-1:0] hx, hy;
  logic                    vis;
  assign hx  = $signed({{(BND_W - 16){head_ent.x[15]}}, head_ent.x});
  assign hy  = $signed({{(BND_W - 16){head_ent.y[15]}}, head_ent.y});
  assign vis = (hx > lo_x_r) && (hy > lo_y_r) && (hx < hi_x_r) && (hy < hi_y_r);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_RENDER: state_nxt = ST_PREP;
            OP_SET, OP_RIGHT, OP_LEFT, OP_UP, OP_DOWN: state_nxt = ST_CAM;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CAM:    state_nxt = (op_r == OP_SET) ? ST_VIEW : ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_VIEW;
      ST_VIEW:   state_nxt = ST_IDLE;
      ST_PREP:   state_nxt = ST_BND;
      ST_BND:    state_nxt = (count_r == '0) ? ST_FRAME : ST_RENDER;
      ST_RENDER: begin
        if ((rot_cnt_r + CNT_W'(1)) == count_r) begin
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and result generation
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt      = count_r;
    rot_cnt_nxt    = rot_cnt_r;
    centre_x_nxt   = centre_x_r;
    centre_y_nxt   = centre_y_r;
    op_nxt         = op_r;
    x_in_nxt       = x_in_r;
    y_in_nxt       = y_in_r;
    off_nxt        = off_r;
    sum_nxt        = sum_r;
    bound_nxt      = bound_r;
    left_nxt       = left_r;
    top_nxt        = top_r;
    lo_x_nxt       = lo_x_r;
    hi_x_nxt       = hi_x_r;
    lo_y_nxt       = lo_y_r;
    hi_y_nxt       = hi_y_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = KIND_OBJ;
    out_id_nxt     = 16'd0;
    out_left_nxt   = '0;
    out_top_nxt    = '0;
    out_last_nxt   = 1'b0;
    cell_ctl.mode  = CELL_HOLD;
    cell_ctl.new_ent.id = in_object_id;
    cell_ctl.new_ent.x  = in_coord_x;
    cell_ctl.new_ent.y  = in_coord_y;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = op_t'(in_op);
          x_in_nxt = in_coord_x;
          y_in_nxt = in_coord_y;
          off_nxt  = in_offset;
          case (in_op)
            OP_CLEAR: count_nxt = '0;
            OP_PUSH: begin
              if (full) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_OVF;
                out_id_nxt    = in_object_id;
                out_last_nxt  = 1'b1;
              end else begin
                cell_ctl.mode = CELL_INSERT;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            default: count_nxt = count_r;
          endcase
        end
      end
      ST_CAM: begin
        if (op_r == OP_SET) begin
          centre_x_nxt = {x_in_r[15], x_in_r, 8'd0};
          centre_y_nxt = {y_in_r[15], y_in_r, 8'd0};
        end else begin
          sum_nxt   = dir_up ? ($signed({c_sel[CTR_W-1], c_sel}) + $signed({10'd0, off_r}))
                             : ($signed({c_sel[CTR_W-1], c_sel}) - $signed({10'd0, off_r}));
          bound_nxt = dir_up ? $signed({lim_diff[LIMIT_W+1], lim_diff, 8'd0})
                             : $signed({6'd0, half_sel, 8'd0});
        end
      end
      ST_CLAMP: begin
        if (axis_y) begin
          centre_y_nxt = c_new;
        end else begin
          centre_x_nxt = c_new;
        end
      end
      ST_VIEW: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_VIEW;
        out_left_nxt  = cur_left;
        out_top_nxt   = cur_top;
        out_last_nxt  = 1'b1;
      end
      ST_PREP: begin
        left_nxt = cur_left;
        top_nxt  = cur_top;
      end
      ST_BND: begin
        // strict window: (left + 64, left + width + 64) on each axis
        lo_x_nxt = $signed({{(BND_W - VIEW_W){left_r[VIEW_W-1]}}, left_r})
                 + $signed(BND_W'(VIEW_MARGIN));
        lo_y_nxt = $signed({{(BND_W - VIEW_W){top_r[VIEW_W-1]}}, top_r})
                 + $signed(BND_W'(VIEW_MARGIN));
        hi_x_nxt = $signed({{(BND_W - VIEW_W){left_r[VIEW_W-1]}}, left_r})
                 + $signed({{(BND_W - SIZE_W){1'b0}}, width_r})
                 + $signed(BND_W'(VIEW_MARGIN));
        hi_y_nxt = $signed({{(BND_W - VIEW_W){top_r[VIEW_W-1]}}, top_r})
                 + $signed({{(BND_W - SIZE_W){1'b0}}, height_r})
                 + $signed(BND_W'(VIEW_MARGIN));
        rot_cnt_nxt = '0;
      end
      ST_RENDER: begin
        cell_ctl.mode = CELL_ROTATE;
        rot_cnt_nxt   = rot_cnt_r + CNT_W'(1);
        if (vis) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_OBJ;
          out_id_nxt    = head_ent.id;
        end
      end
      ST_FRAME: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_FRAME;
        out_left_nxt  = left_r;
        out_top_nxt   = top_r;
        out_last_nxt  = 1'b1;
      end
      default: begin
        cell_ctl.mode = CELL_HOLD;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    width_nxt      = width_r;
    height_nxt     = height_r;
    lim_right_nxt  = lim_right_r;
    lim_bottom_nxt = lim_bottom_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_WIDTH:   width_nxt      = cfg_wdata[SIZE_W-1:0];
        CFG_VIEW_HEIGHT:  height_nxt     = cfg_wdata[SIZE_W-1:0];
        CFG_LIMIT_RIGHT:  lim_right_nxt  = cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_BOTTOM: lim_bottom_nxt = cfg_wdata[LIMIT_W-1:0];
        default:          width_nxt      = width_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rot_cnt_r    <= '0;
      centre_x_r   <= '0;
      centre_y_r   <= '0;
      width_r      <= RST_VIEW_WIDTH;
      height_r     <= RST_VIEW_HEIGHT;
      lim_right_r  <= RST_LIMIT_RIGHT;
      lim_bottom_r <= RST_LIMIT_BOTTOM;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rot_cnt_r    <= rot_cnt_nxt;
      centre_x_r   <= centre_x_nxt;
      centre_y_r   <= centre_y_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      lim_right_r  <= lim_right_nxt;
      lim_bottom_r <= lim_bottom_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_in_r     <= x_in_nxt;
    y_in_r     <= y_in_nxt;
    off_r      <= off_nxt;
    sum_r      <= sum_nxt;
    bound_r    <= bound_nxt;
    left_r     <= left_nxt;
    top_r      <= top_nxt;
    lo_x_r     <= lo_x_nxt;
    hi_x_r     <= hi_x_nxt;
    lo_y_r     <= lo_y_nxt;
    hi_y_r     <= hi_y_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_left_r <= out_left_nxt;
    out_top_r  <= out_top_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_object_id_res = out_id_r;
  assign out_view_left     = out_left_r;
  assign out_view_top      = out_top_r;
  assign out_last          = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `DRQ_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `DRQ_ASSERT_IMP(a_sorted_split, clk, rst_n, cell_ctl.mode == CELL_INSERT, ((gt_vec << 1) & ~gt_vec) == '0)
  `DRQ_ASSERT_IMP(a_render_nonempty, clk, rst_n, state_r == ST_RENDER, count_r != '0)
  `DRQ_ASSERT_NXT(a_overflow_result, clk, rst_n, accept && (in_op == OP_PUSH) && full, out_valid_r && (out_kind_r == KIND_OVF) && out_last_r)
  `DRQ_ASSERT_NXT(a_frame_result, clk, rst_n, state_r == ST_FRAME, out_valid_r && (out_kind_r == KIND_FRAME) && out_last_r)

endmodule
`default_nettype wire
